FILE: sv/tmf_pkg.sv
// ----------------------------------------------------------------------------
// tmf_pkg: shared types and constants of the track motion feature pipeline
// Field widths, register map, reset values and the wide arithmetic types.
// ----------------------------------------------------------------------------
`default_nettype none

package tmf_pkg;

   // Fraction bits of the fixed-point fields.
   localparam int FRAC_BITS = 16;

   // Stream and register port sizes.
   localparam int IN_W   = 320;
   localparam int OUT_W  = 152;
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   // Field widths.
   localparam int SPEED_W  = 28;
   localparam int ACC_W    = 27;
   localparam int HEIGHT_W = 31;
   localparam int VEL_W    = 29;
   localparam int PLAT_W   = 31;
   localparam int TRACE_W  = 32;
   localparam int ALT_W    = 33;
   localparam int RAD_W    = 40;
   localparam int QUAL_W   = 17;
   localparam int MINSQ_W  = 16;
   localparam int LIMIT_W  = 24;
   localparam int KNEE_BITS = 20;

   // Internal arithmetic widths.
   localparam int PROD_W  = 56;             // velocity times acceleration
   localparam int VSQ_W   = 57;             // one velocity component squared
   localparam int V2_W    = 58;             // squared speed from the vector
   localparam int CABS_W  = 56;             // magnitude of a cross component
   localparam int HALF_W  = 28;             // half of a cross component
   localparam int C2_W    = 112;            // squared cross product
   localparam int QN_W    = 54;             // squared lateral acceleration
   localparam int LAT_W   = 27;             // lateral acceleration
   localparam int SQR_W   = 29;             // square root partial remainder
   localparam int SPSQ_W  = 56;             // speed squared
   localparam int DIV_N   = 54;
   localparam int SQRT_N  = 27;
   localparam int RDIV_N  = 40;

   localparam logic [RAD_W-1:0] RADIUS_MAX = {RAD_W{1'b1}};

   // Output bit positions used by the checks.
   localparam int OUT_STRAIGHT_BIT = 88;
   localparam int OUT_RADIUS_LSB   = 89;

   typedef enum logic [1:0] {
      REG_MIN_SPEED_SQ  = 2'd0,
      REG_LATERAL_LIMIT = 2'd1,
      REG_QUALITY_KNEE  = 2'd2
   } reg_index_type;

   localparam logic [MINSQ_W-1:0]   MIN_SPEED_SQ_RESET  = 16'd7;
   localparam logic [LIMIT_W-1:0]   LATERAL_LIMIT_RESET = 24'd655;
   localparam logic [KNEE_BITS-1:0] QUALITY_KNEE_RESET  = 20'd10000;

   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [VSQ_W:0]    vsq_type;
   typedef logic signed [PROD_W:0]   diff_type;
   typedef logic        [V2_W-1:0]   v2_type;
   typedef logic        [2*HALF_W-1:0] half_sq_type;
   typedef logic        [C2_W-1:0]   c2_type;
   typedef logic        [SPSQ_W-1:0] spsq_type;
   typedef logic signed [ALT_W-1:0]  alt_type;

   typedef struct packed {
      logic                       confirmed;
      logic        [SPEED_W-1:0]  speed;
      logic signed [ACC_W-1:0]    accel;
      logic signed [HEIGHT_W-1:0] height;
      logic signed [VEL_W-1:0]    vel_x;
      logic signed [VEL_W-1:0]    vel_y;
      logic signed [VEL_W-1:0]    vel_z;
      logic signed [ACC_W-1:0]    acc_x;
      logic signed [ACC_W-1:0]    acc_y;
      logic signed [ACC_W-1:0]    acc_z;
      logic        [PLAT_W-1:0]   plat;
      logic signed [TRACE_W-1:0]  trace;
   } in_type;

endpackage

`default_nettype wire

FILE: sv/track_motion_features.sv
// Throughput: one beat per cycle; the pipeline only stops when its last stage
// holds a result and the output register is still waiting on rsp_tready.
// The depth is set by the 54-step division, 27-step square root and 40-step
// radius division, one restoring step per stage.
// Reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
// track_motion_features: motion features of one radar track snapshot
// Altitude, straight-flight test, turn radius and track quality, one track
// per beat, with an APB-style register port for the thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

module track_motion_features
   import tmf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // speed_in, accel_in, height_rel, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z,
   // platform_altitude, uncertainty_trace, zero fill
   input  logic [IN_W-1:0]   req_tdata,
   // confirmed
   input  logic              req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // speed_out, accel_out, altitude, straight, turn_radius, quality, zero fill
   output logic [OUT_W-1:0]  rsp_tdata,
   // valid_res
   output logic              rsp_tuser,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   localparam int KNEE_W  = KNEE_BITS + FRAC_BITS;
   localparam int TPOS_W  = TRACE_W - 1;
   localparam int DEN_W   = ((KNEE_W > TPOS_W) ? KNEE_W : TPOS_W) + 1;
   localparam int QW      = FRAC_BITS + 1;

   typedef logic [DEN_W-1:0] den_type;

   typedef struct packed {
      logic               conf;
      logic [SPEED_W-1:0] speed;
      logic [ACC_W-1:0]   accel;
      logic [ALT_W-1:0]   altitude;
      logic [SPSQ_W-1:0]  spsq;
      logic               slow;
      logic [DEN_W-1:0]   den;
      logic [DEN_W-1:0]   qrem;
      logic [QW-1:0]      qq;
   } side_type;

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   logic [MINSQ_W-1:0]   min_speed_sq_ff;
   logic [LIMIT_W-1:0]   lat_limit_ff;
   logic [KNEE_BITS-1:0] knee_ff;
   reg_index_type        csr_idx;
   logic                 csr_wr;

   assign csr_idx    = reg_index_type'(csr_paddr[CSR_AW-1:2]);
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_speed_sq_ff <= MIN_SPEED_SQ_RESET;
         lat_limit_ff    <= LATERAL_LIMIT_RESET;
         knee_ff         <= QUALITY_KNEE_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_MIN_SPEED_SQ:  min_speed_sq_ff <= csr_pwdata[MINSQ_W-1:0];
            REG_LATERAL_LIMIT: lat_limit_ff    <= csr_pwdata[LIMIT_W-1:0];
            REG_QUALITY_KNEE:  knee_ff         <= csr_pwdata[KNEE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_MIN_SPEED_SQ:  csr_prdata = CSR_DW'(min_speed_sq_ff);
         REG_LATERAL_LIMIT: csr_prdata = CSR_DW'(lat_limit_ff);
         REG_QUALITY_KNEE:  csr_prdata = CSR_DW'(knee_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Flow control: every stage moves together unless the last stage is full
   // and the output register is still held.
   // ------------------------------------------------------------------------
   logic en;
   logic out_v_ff;
   logic rd_last_v;

   assign en         = !(out_v_ff && !rsp_tready && rd_last_v);
   assign req_tready = en;

   // ------------------------------------------------------------------------
   // Stage A: input register
   // ------------------------------------------------------------------------
   in_type req_fields;
   in_type a_ff;
   logic   a_v_ff;

   always_comb begin
      req_fields.confirmed = req_tuser;
      req_fields.speed     = req_tdata[27:0];
      req_fields.accel     = req_tdata[54:28];
      req_fields.height    = req_tdata[85:55];
      req_fields.vel_x     = req_tdata[114:86];
      req_fields.vel_y     = req_tdata[143:115];
      req_fields.vel_z     = req_tdata[172:144];
      req_fields.acc_x     = req_tdata[199:173];
      req_fields.acc_y     = req_tdata[226:200];
      req_fields.acc_z     = req_tdata[253:227];
      req_fields.plat      = req_tdata[284:254];
      req_fields.trace     = req_tdata[316:285];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (en) begin
         a_v_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff <= req_fields;
      end
   end

   // ------------------------------------------------------------------------
   // Stage B: component squares, cross-product terms, altitude, quality operands, speed squared
   // ------------------------------------------------------------------------
   logic [VSQ_W-1:0] b_vsq_ff [3];
   prod_type         b_pm_ff  [6];
   side_type         b_side_ff;
   logic             b_v_ff;
   vsq_type          vsq_w [3];
   side_type         b_side_in;
   logic [TPOS_W-1:0] tpos;
   logic [KNEE_W-1:0] knee_ext;

   always_comb begin
      vsq_w[0] = vsq_type'(a_ff.vel_x) * vsq_type'(a_ff.vel_x);
      vsq_w[1] = vsq_type'(a_ff.vel_y) * vsq_type'(a_ff.vel_y);
      vsq_w[2] = vsq_type'(a_ff.vel_z) * vsq_type'(a_ff.vel_z);
      tpos     = a_ff.trace[TRACE_W-1] ? '0 : a_ff.trace[TPOS_W-1:0];
      knee_ext = {knee_ff, {FRAC_BITS{1'b0}}};
      b_side_in.conf     = a_ff.confirmed;
      b_side_in.speed    = a_ff.speed;
      b_side_in.accel    = a_ff.accel;
      b_side_in.altitude = alt_type'({1'b0, a_ff.plat}) + alt_type'(a_ff.height);
      b_side_in.spsq     = spsq_type'(a_ff.speed) * spsq_type'(a_ff.speed);
      b_side_in.slow     = 1'b0;
      b_side_in.den      = den_type'(knee_ext) + den_type'(tpos);
      b_side_in.qrem     = den_type'(knee_ext);
      b_side_in.qq       = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (en) begin
         b_v_ff <= a_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_vsq_ff[0] <= vsq_w[0][VSQ_W-1:0];
         b_vsq_ff[1] <= vsq_w[1][VSQ_W-1:0];
         b_vsq_ff[2] <= vsq_w[2][VSQ_W-1:0];
         b_pm_ff[0]  <= prod_type'(a_ff.vel_y) * prod_type'(a_ff.acc_z);
         b_pm_ff[1]  <= prod_type'(a_ff.vel_z) * prod_type'(a_ff.acc_y);
         b_pm_ff[2]  <= prod_type'(a_ff.vel_z) * prod_type'(a_ff.acc_x);
         b_pm_ff[3]  <= prod_type'(a_ff.vel_x) * prod_type'(a_ff.acc_z);
         b_pm_ff[4]  <= prod_type'(a_ff.vel_x) * prod_type'(a_ff.acc_y);
         b_pm_ff[5]  <= prod_type'(a_ff.vel_y) * prod_type'(a_ff.acc_x);
         b_side_ff   <= b_side_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage C: squared speed and cross-product magnitudes
   // ------------------------------------------------------------------------
   v2_type            c_v2_ff;
   logic [CABS_W-1:0] c_abs_ff [3];
   side_type          c_side_ff;
   logic              c_v_ff;
   diff_type          cdiff [3];
   diff_type          cmag  [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cdiff[i] = diff_type'(b_pm_ff[2*i]) - diff_type'(b_pm_ff[2*i+1]);
         cmag[i]  = cdiff[i][PROD_W] ? -cdiff[i] : cdiff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
      end else if (en) begin
         c_v_ff <= b_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_v2_ff   <= v2_type'(b_vsq_ff[0]) + v2_type'(b_vsq_ff[1]) + v2_type'(b_vsq_ff[2]);
         c_side_ff <= b_side_ff;
         for (int i = 0; i < 3; i++) begin
            c_abs_ff[i] <= cmag[i][CABS_W-1:0];
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stage D: slow-speed test and half-width partial products of each cross component squared
   // ------------------------------------------------------------------------
   v2_type      d_v2_ff;
   half_sq_type d_hh_ff [3];
   half_sq_type d_hl_ff [3];
   half_sq_type d_ll_ff [3];
   side_type    d_side_ff;
   logic        d_v_ff;
   side_type    d_side_in;

   always_comb begin
      d_side_in      = c_side_ff;
      d_side_in.slow = c_v2_ff <= V2_W'({min_speed_sq_ff, {FRAC_BITS{1'b0}}});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_v_ff <= 1'b0;
      end else if (en) begin
         d_v_ff <= c_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_v2_ff   <= c_v2_ff;
         d_side_ff <= d_side_in;
         for (int i = 0; i < 3; i++) begin
            d_hh_ff[i] <= half_sq_type'(c_abs_ff[i][CABS_W-1:HALF_W])
                          * half_sq_type'(c_abs_ff[i][CABS_W-1:HALF_W]);
            d_hl_ff[i] <= half_sq_type'(c_abs_ff[i][CABS_W-1:HALF_W])
                          * half_sq_type'(c_abs_ff[i][HALF_W-1:0]);
            d_ll_ff[i] <= half_sq_type'(c_abs_ff[i][HALF_W-1:0])
                          * half_sq_type'(c_abs_ff[i][HALF_W-1:0]);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stage E: each cross component squared; stage F: their sum
   // ------------------------------------------------------------------------
   v2_type   e_v2_ff;
   c2_type   e_csq_ff [3];
   side_type e_side_ff;
   logic     e_v_ff;
   v2_type   f_v2_ff;
   c2_type   f_c2_ff;
   side_type f_side_ff;
   logic     f_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_v_ff <= 1'b0;
         f_v_ff <= 1'b0;
      end else if (en) begin
         e_v_ff <= d_v_ff;
         f_v_ff <= e_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_v2_ff   <= d_v2_ff;
         e_side_ff <= d_side_ff;
         for (int i = 0; i < 3; i++) begin
            e_csq_ff[i] <= (c2_type'(d_hh_ff[i]) << (2*HALF_W))
                           + (c2_type'(d_hl_ff[i]) << (HALF_W+1))
                           + c2_type'(d_ll_ff[i]);
         end
         f_v2_ff   <= e_v2_ff;
         f_c2_ff   <= e_csq_ff[0] + e_csq_ff[1] + e_csq_ff[2];
         f_side_ff <= e_side_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Division of the squared cross product by the squared speed, one
   // quotient bit per stage. The quality division rides in the first stages.
   // ------------------------------------------------------------------------
   logic [V2_W-1:0] dv_rem_ff  [DIV_N];
   logic [QN_W-1:0] dv_low_ff  [DIV_N];
   v2_type          dv_d_ff    [DIV_N];
   side_type        dv_side_ff [DIV_N];
   logic            dv_v_ff    [DIV_N];

   for (genvar k = 0; k < DIV_N; k++) begin : g_div
      logic [V2_W-1:0] rem_src;
      logic [QN_W-1:0] low_src;
      v2_type          d_src;
      side_type        side_src;
      logic            v_src;
      logic [V2_W:0]   t;
      logic [V2_W:0]   tsub;
      logic            ge;
      side_type        side_nx;

      if (k == 0) begin : g_first
         assign rem_src  = f_c2_ff[C2_W-1:QN_W];
         assign low_src  = f_c2_ff[QN_W-1:0];
         assign d_src    = f_v2_ff;
         assign side_src = f_side_ff;
         assign v_src    = f_v_ff;
      end else begin : g_next
         assign rem_src  = dv_rem_ff[k-1];
         assign low_src  = dv_low_ff[k-1];
         assign d_src    = dv_d_ff[k-1];
         assign side_src = dv_side_ff[k-1];
         assign v_src    = dv_v_ff[k-1];
      end

      assign t    = {rem_src, low_src[QN_W-1]};
      assign tsub = t - {1'b0, d_src};
      assign ge   = t >= {1'b0, d_src};

      if (k <= FRAC_BITS) begin : g_qual
         logic [DEN_W:0] qt;
         logic [DEN_W:0] qsub;
         logic           qge;
         // The first step compares the knee itself, the others the doubled rest.
         assign qt   = (k == 0) ? {1'b0, side_src.qrem} : {side_src.qrem, 1'b0};
         assign qsub = qt - {1'b0, side_src.den};
         assign qge  = qt >= {1'b0, side_src.den};
         always_comb begin
            side_nx      = side_src;
            side_nx.qrem = qge ? qsub[DEN_W-1:0] : qt[DEN_W-1:0];
            side_nx.qq   = {side_src.qq[QW-2:0], qge};
         end
      end else begin : g_hold
         assign side_nx = side_src;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[k] <= 1'b0;
         end else if (en) begin
            dv_v_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dv_rem_ff[k]  <= ge ? tsub[V2_W-1:0] : t[V2_W-1:0];
            dv_low_ff[k]  <= {low_src[QN_W-2:0], ge};
            dv_d_ff[k]    <= d_src;
            dv_side_ff[k] <= side_nx;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Integer square root of the quotient: the lateral acceleration
   // ------------------------------------------------------------------------
   logic [SQR_W-1:0] sr_rem_ff  [SQRT_N];
   logic [LAT_W-1:0] sr_root_ff [SQRT_N];
   logic [QN_W-1:0]  sr_q_ff    [SQRT_N];
   side_type         sr_side_ff [SQRT_N];
   logic             sr_v_ff    [SQRT_N];

   for (genvar k = 0; k < SQRT_N; k++) begin : g_sqrt
      logic [SQR_W-1:0] rem_src;
      logic [LAT_W-1:0] root_src;
      logic [QN_W-1:0]  q_src;
      side_type         side_src;
      logic             v_src;
      logic [SQR_W+1:0] r4;
      logic [SQR_W+1:0] trial;
      logic [SQR_W+1:0] rsub;
      logic             ge;

      if (k == 0) begin : g_first
         assign rem_src  = '0;
         assign root_src = '0;
         assign q_src    = dv_low_ff[DIV_N-1];
         assign side_src = dv_side_ff[DIV_N-1];
         assign v_src    = dv_v_ff[DIV_N-1];
      end else begin : g_next
         assign rem_src  = sr_rem_ff[k-1];
         assign root_src = sr_root_ff[k-1];
         assign q_src    = sr_q_ff[k-1];
         assign side_src = sr_side_ff[k-1];
         assign v_src    = sr_v_ff[k-1];
      end

      assign r4    = {rem_src, q_src[QN_W-1:QN_W-2]};
      assign trial = {2'b00, root_src, 2'b01};
      assign rsub  = r4 - trial;
      assign ge    = r4 >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            sr_v_ff[k] <= 1'b0;
         end else if (en) begin
            sr_v_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sr_rem_ff[k]  <= ge ? rsub[SQR_W-1:0] : r4[SQR_W-1:0];
            sr_root_ff[k] <= {root_src[LAT_W-2:0], ge};
            sr_q_ff[k]    <= {q_src[QN_W-3:0], 2'b00};
            sr_side_ff[k] <= side_src;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stage L: straight-flight decision and radius saturation test
   // ------------------------------------------------------------------------
   logic [LAT_W-1:0] l_lat_ff;
   logic             l_straight_ff;
   logic             l_sat_ff;
   side_type         l_side_ff;
   logic             l_v_ff;
   logic [LAT_W-1:0] lat_w;
   side_type         sr_last;

   assign lat_w   = sr_root_ff[SQRT_N-1];
   assign sr_last = sr_side_ff[SQRT_N-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         l_v_ff <= 1'b0;
      end else if (en) begin
         l_v_ff <= sr_v_ff[SQRT_N-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         l_lat_ff      <= lat_w;
         l_straight_ff <= sr_last.slow || (lat_w < LAT_W'(lat_limit_ff));
         // At or above the top radius bit the quotient would not fit.
         l_sat_ff      <= LAT_W'(sr_last.spsq[SPSQ_W-1:RAD_W]) >= lat_w;
         l_side_ff     <= sr_last;
      end
   end

   // ------------------------------------------------------------------------
   // Radius division: speed squared over lateral acceleration
   // ------------------------------------------------------------------------
   logic [LAT_W-1:0] rd_rem_ff      [RDIV_N];
   logic [RAD_W-1:0] rd_low_ff      [RDIV_N];
   logic [LAT_W-1:0] rd_lat_ff      [RDIV_N];
   logic             rd_straight_ff [RDIV_N];
   logic             rd_sat_ff      [RDIV_N];
   side_type         rd_side_ff     [RDIV_N];
   logic             rd_v_ff        [RDIV_N];

   for (genvar k = 0; k < RDIV_N; k++) begin : g_rdiv
      logic [LAT_W-1:0] rem_src;
      logic [RAD_W-1:0] low_src;
      logic [LAT_W-1:0] lat_src;
      logic             straight_src;
      logic             sat_src;
      side_type         side_src;
      logic             v_src;
      logic [LAT_W:0]   t;
      logic [LAT_W:0]   tsub;
      logic             ge;

      if (k == 0) begin : g_first
         assign rem_src      = LAT_W'(l_side_ff.spsq[SPSQ_W-1:RAD_W]);
         assign low_src      = l_side_ff.spsq[RAD_W-1:0];
         assign lat_src      = l_lat_ff;
         assign straight_src = l_straight_ff;
         assign sat_src      = l_sat_ff;
         assign side_src     = l_side_ff;
         assign v_src        = l_v_ff;
      end else begin : g_next
         assign rem_src      = rd_rem_ff[k-1];
         assign low_src      = rd_low_ff[k-1];
         assign lat_src      = rd_lat_ff[k-1];
         assign straight_src = rd_straight_ff[k-1];
         assign sat_src      = rd_sat_ff[k-1];
         assign side_src     = rd_side_ff[k-1];
         assign v_src        = rd_v_ff[k-1];
      end

      assign t    = {rem_src, low_src[RAD_W-1]};
      assign tsub = t - {1'b0, lat_src};
      assign ge   = t >= {1'b0, lat_src};

      always_ff @(posedge clock) begin
         if (reset) begin
            rd_v_ff[k] <= 1'b0;
         end else if (en) begin
            rd_v_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rd_rem_ff[k]      <= ge ? tsub[LAT_W-1:0] : t[LAT_W-1:0];
            rd_low_ff[k]      <= {low_src[RAD_W-2:0], ge};
            rd_lat_ff[k]      <= lat_src;
            rd_straight_ff[k] <= straight_src;
            rd_sat_ff[k]      <= sat_src;
            rd_side_ff[k]     <= side_src;
         end
      end
   end

   assign rd_last_v = rd_v_ff[RDIV_N-1];

   // ------------------------------------------------------------------------
   // Output register
   // ------------------------------------------------------------------------
   logic [OUT_W-1:0]  out_data_ff;
   logic              out_user_ff;
   logic [OUT_W-1:0]  out_data_in;
   logic [RAD_W-1:0]  radius_w;
   logic [QUAL_W-1:0] quality_w;
   side_type          rd_last;

   assign rd_last = rd_side_ff[RDIV_N-1];

   always_comb begin
      if (rd_straight_ff[RDIV_N-1]) begin
         radius_w = '0;
      end else if (rd_sat_ff[RDIV_N-1]) begin
         radius_w = RADIUS_MAX;
      end else begin
         radius_w = rd_low_ff[RDIV_N-1];
      end
      quality_w = (rd_last.den == '0) ? '0 : QUAL_W'(rd_last.qq);
      if (rd_last.conf) begin
         out_data_in = {6'b0, quality_w, radius_w, rd_straight_ff[RDIV_N-1],
                        rd_last.altitude, rd_last.accel, rd_last.speed};
      end else begin
         out_data_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (!out_v_ff || rsp_tready) begin
         out_v_ff <= rd_last_v;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_v_ff || rsp_tready) begin
         out_data_ff <= out_data_in;
         out_user_ff <= rd_last.conf;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

`ifndef SYNTH
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("unconfirmed track gave a nonzero result");

   a_straight_radius: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[OUT_STRAIGHT_BIT]
      |-> rsp_tdata[OUT_RADIUS_LSB+RAD_W-1:OUT_RADIUS_LSB] == '0)
      else $error("straight track with a nonzero turn radius");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled while the output side was free");
`endif

endmodule

`default_nettype wire

FILE: verif/track_motion_features_tb.sv
// ----------------------------------------------------------------------------
// track_motion_features_tb: self-checking bench for the track feature pipeline
// Drives track snapshots on the req stream in random bursts, stalls the rsp
// stream on its own pattern, and compares every rsp beat field by field with
// an in-bench predictor. Register settings change between traffic phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module track_motion_features_tb;
   import tmf_pkg::*;

   typedef struct packed {
      logic                 valid;
      logic [SPEED_W-1:0]   speed;
      logic [ACC_W-1:0]     accel;
      logic [ALT_W-1:0]     alt;
      logic                 straight;
      logic [RAD_W-1:0]     radius;
      logic [QUAL_W-1:0]    quality;
   } features_type;

   typedef struct {
      in_type       trk;
      bit           typed;
      features_type want;
   } track_row_type;

   localparam int IDLE_LIMIT  = 5000;
   localparam int DRAIN_WAIT  = 200;
   localparam int HOLD_CYCLES = 400;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [IN_W-1:0]   req_tdata;
   logic              req_tuser;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [OUT_W-1:0]  rsp_tdata;
   logic              rsp_tuser;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   track_motion_features dut (.*);

   // Register copies kept by the predictor.
   logic [MINSQ_W-1:0]   min_sq_reg;
   logic [LIMIT_W-1:0]   lat_limit_reg;
   logic [KNEE_BITS-1:0] knee_reg;

   features_type  pending_features[$];
   int            mismatches;
   int            rsp_count;
   int            sent_count;
   int            turn_count;
   int            sat_count;
   int            burst_left;
   bit            hold_pending;
   track_row_type directed[$];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic features_type predict_features(in_type t);
      features_type f;
      longint vx, vy, vz, ax, ay, az;
      longint unsigned cx, cy, cz, v2, lat, cand, knee, den, spsq;
      logic [127:0] c2, w;
      f = '0;
      if (!t.confirmed) return f;
      vx = t.vel_x; vy = t.vel_y; vz = t.vel_z;
      ax = t.acc_x; ay = t.acc_y; az = t.acc_z;
      f.valid = 1'b1;
      f.speed = t.speed;
      f.accel = t.accel;
      f.alt   = {2'b00, t.plat} + {{2{t.height[HEIGHT_W-1]}}, t.height};
      f.straight = 1'b1;
      v2 = vx * vx + vy * vy + vz * vz;
      if (v2 > (64'(min_sq_reg) << FRAC_BITS)) begin
         cx = (vy * az - vz * ay < 0) ? -(vy * az - vz * ay) : vy * az - vz * ay;
         cy = (vz * ax - vx * az < 0) ? -(vz * ax - vx * az) : vz * ax - vx * az;
         cz = (vx * ay - vy * ax < 0) ? -(vx * ay - vy * ax) : vx * ay - vy * ax;
         c2 = 128'(cx) * 128'(cx) + 128'(cy) * 128'(cy) + 128'(cz) * 128'(cz);
         lat = 0;
         for (int b = 28; b >= 0; b--) begin
            cand = lat | (64'd1 << b);
            w = 128'(cand * cand) * 128'(v2);
            if (w <= c2) lat = cand;
         end
         if (lat >= 64'(lat_limit_reg)) begin
            f.straight = 1'b0;
            spsq = 64'(t.speed) * 64'(t.speed);
            if (lat == 0 || spsq / lat > 64'(RADIUS_MAX)) f.radius = RADIUS_MAX;
            else f.radius = RAD_W'(spsq / lat);
         end
      end
      knee = 64'(knee_reg) << FRAC_BITS;
      den  = knee + ((t.trace > 0) ? 64'(t.trace) : 64'd0);
      if (den != 0) f.quality = QUAL_W'((128'(knee) << FRAC_BITS) / 128'(den));
      return f;
   endfunction

   function automatic logic [IN_W-1:0] pack_track(in_type t);
      return IN_W'({t.trace, t.plat, t.acc_z, t.acc_y, t.acc_x,
                    t.vel_z, t.vel_y, t.vel_x, t.height, t.accel, t.speed});
   endfunction

   function automatic in_type random_track();
      in_type t;
      int vmode, amode;
      t.confirmed = ($urandom_range(0, 9) != 0);
      t.speed  = ($urandom_range(0, 2) == 0) ? SPEED_W'($urandom_range(0, 1 << 20))
                                              : SPEED_W'($urandom);
      t.accel  = ACC_W'($urandom);
      t.height = HEIGHT_W'($urandom);
      t.plat   = PLAT_W'($urandom);
      case ($urandom_range(0, 3))
         0: t.trace = '0;
         1: t.trace = $urandom_range(0, 1 << 30);
         default: t.trace = $urandom;
      endcase
      vmode = $urandom_range(0, 5);
      amode = $urandom_range(0, 5);
      if (vmode <= 1) begin
         t.vel_x = VEL_W'($urandom); t.vel_y = VEL_W'($urandom); t.vel_z = VEL_W'($urandom);
      end else if (vmode == 5) begin
         t.vel_x = VEL_W'($signed($urandom_range(0, 8)) - 4);
         t.vel_y = VEL_W'($signed($urandom_range(0, 8)) - 4);
         t.vel_z = '0;
      end else begin
         t.vel_x = VEL_W'($signed($urandom_range(0, 8192)) - 4096);
         t.vel_y = VEL_W'($signed($urandom_range(0, 8192)) - 4096);
         t.vel_z = VEL_W'($signed($urandom_range(0, 8192)) - 4096);
      end
      if (amode <= 1) begin
         t.acc_x = ACC_W'($urandom); t.acc_y = ACC_W'($urandom); t.acc_z = ACC_W'($urandom);
      end else if (amode == 2 && vmode >= 2) begin
         // Acceleration along the velocity leaves no lateral part.
         amode = $signed($urandom_range(0, 16)) - 8;
         t.acc_x = ACC_W'(t.vel_x * amode);
         t.acc_y = ACC_W'(t.vel_y * amode);
         t.acc_z = ACC_W'(t.vel_z * amode);
      end else if (amode == 3) begin
         t.acc_x = '0; t.acc_y = '0; t.acc_z = '0;
      end else begin
         t.acc_x = ACC_W'($signed($urandom_range(0, 2048)) - 1024);
         t.acc_y = ACC_W'($signed($urandom_range(0, 2048)) - 1024);
         t.acc_z = ACC_W'($signed($urandom_range(0, 2048)) - 1024);
      end
      return t;
   endfunction

   task automatic send_track(in_type t, features_type want);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 40);
         gap = $urandom_range(0, 8);
         if (gap > 0) begin
            @(negedge clock) req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      pending_features.push_back(want);
      sent_count++;
      @(negedge clock);
      req_tdata  <= pack_track(t);
      req_tuser  <= t.confirmed;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic csr_write(reg_index_type idx, logic [CSR_DW-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= CSR_AW'(idx) << 2;
      csr_pwdata  <= value;
      @(negedge clock) csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_thresholds(int unsigned msq, int unsigned lim, int unsigned knee);
      csr_write(REG_MIN_SPEED_SQ, msq);
      csr_write(REG_LATERAL_LIMIT, lim);
      csr_write(REG_QUALITY_KNEE, knee);
      min_sq_reg    = MINSQ_W'(msq);
      lat_limit_reg = LIMIT_W'(lim);
      knee_reg      = KNEE_BITS'(knee);
   endtask

   task automatic wait_drained();
      @(negedge clock) req_tvalid <= 1'b0;
      while (pending_features.size() != 0) @(posedge clock);
   endtask

   task automatic run_random(int count);
      in_type t;
      hold_pending = 1'b1;
      repeat (count) begin
         t = random_track();
         send_track(t, predict_features(t));
      end
      wait_drained();
   endtask

   task automatic add_row(in_type t, bit typed, features_type want);
      track_row_type r;
      r.trk = t; r.typed = typed; r.want = want;
      directed.push_back(r);
   endtask

   task automatic build_directed();
      in_type t;
      features_type zero_f, f;
      zero_f = '0;
      t = '1; t.confirmed = 1'b0;
      add_row(t, 1'b1, zero_f);                 // invalid track, every bit set
      t = '0;
      add_row(t, 1'b1, zero_f);                 // invalid track, all clear
      t.confirmed = 1'b1;
      f = zero_f; f.valid = 1'b1; f.straight = 1'b1; f.quality = 17'd65536;
      add_row(t, 1'b1, f);                      // standing still, zero trace
      t = '0; t.confirmed = 1'b1;
      t.speed = '1; t.accel = {1'b1, {(ACC_W-1){1'b0}}};
      t.height = {1'b1, {(HEIGHT_W-1){1'b0}}}; t.plat = '1;
      t.trace = {1'b0, {(TRACE_W-1){1'b1}}};
      add_row(t, 1'b0, zero_f);
      t = '0; t.confirmed = 1'b1;
      t.accel = {1'b0, {(ACC_W-1){1'b1}}}; t.height = {1'b0, {(HEIGHT_W-1){1'b1}}};
      t.trace = {1'b1, {(TRACE_W-1){1'b0}}};
      add_row(t, 1'b0, zero_f);
      t = '0; t.confirmed = 1'b1;
      t.speed = SPEED_W'(1 << 16); t.vel_x = VEL_W'(1 << 16); t.acc_y = ACC_W'(100 << 16);
      add_row(t, 1'b0, zero_f);                 // plain level turn
      t.vel_x = {1'b0, {(VEL_W-1){1'b1}}}; t.acc_y = {1'b0, {(ACC_W-1){1'b1}}};
      add_row(t, 1'b0, zero_f);
      t.vel_x = {1'b1, {(VEL_W-1){1'b0}}}; t.vel_y = t.vel_x; t.vel_z = t.vel_x;
      t.acc_x = {1'b1, {(ACC_W-1){1'b0}}}; t.acc_y = t.acc_x; t.acc_z = t.acc_x;
      add_row(t, 1'b0, zero_f);
      t = '0; t.confirmed = 1'b1;
      t.vel_x = VEL_W'(5 << 16); t.acc_x = ACC_W'(3 << 16);
      add_row(t, 1'b0, zero_f);                 // acceleration along the path
      t = '0; t.confirmed = 1'b1;
      t.speed = '1; t.vel_x = VEL_W'(4 << 16); t.acc_y = ACC_W'(700);
      add_row(t, 1'b0, zero_f);                 // radius beyond the maximum
      t = '0; t.confirmed = 1'b1;
      t.vel_x = VEL_W'(2); t.acc_y = ACC_W'(1 << 20);
      add_row(t, 1'b0, zero_f);                 // too slow to judge a turn
      t = '0; t.confirmed = 1'b1;
      t.trace = 10000 << 16;
      add_row(t, 1'b0, zero_f);                 // quality one half
   endtask

   // Receiver stall pattern, with one long hold-off per phase.
   initial begin
      int mode_left;
      int mode;
      rsp_tready = 1'b0;
      mode_left  = 0;
      mode       = 0;
      forever begin
         @(negedge clock);
         if (hold_pending && !reset) begin
            hold_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if (mode_left == 0) begin
            mode_left = $urandom_range(16, 128);
            mode = $urandom_range(0, 3);
         end
         mode_left--;
         case (mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 1) == 0);
            2: rsp_tready <= ($urandom_range(0, 9) != 0);
            default: rsp_tready <= ($urandom_range(0, 9) == 0);
         endcase
      end
   end

   // Result checking.
   always @(posedge clock) begin
      features_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.valid    = rsp_tuser;
         got.speed    = rsp_tdata[27:0];
         got.accel    = rsp_tdata[54:28];
         got.alt      = rsp_tdata[87:55];
         got.straight = rsp_tdata[88];
         got.radius   = rsp_tdata[128:89];
         got.quality  = rsp_tdata[145:129];
         rsp_count++;
         if (pending_features.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("rsp beat %0d arrived with none pending", rsp_count);
         end else begin
            want = pending_features.pop_front();
            if (got.valid && !got.straight) turn_count++;
            if (got.radius == RADIUS_MAX) sat_count++;
            if (got != want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("rsp beat %0d: valid %0d/%0d speed %h/%h accel %h/%h alt %h/%h",
                           rsp_count, want.valid, got.valid, want.speed, got.speed,
                           want.accel, got.accel, want.alt, got.alt);
                  $display("   straight %0d/%0d radius %h/%h quality %h/%h (expected/actual)",
                           want.straight, got.straight, want.radius, got.radius,
                           want.quality, got.quality);
               end
            end
         end
      end
   end

   // Watchdog on cycles without any accepted beat.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      mismatches  = 0;
      rsp_count   = 0;
      sent_count  = 0;
      turn_count  = 0;
      sat_count   = 0;
      burst_left  = 0;
      hold_pending = 1'b0;
      min_sq_reg    = MIN_SPEED_SQ_RESET;
      lat_limit_reg = LATERAL_LIMIT_RESET;
      knee_reg      = QUALITY_KNEE_RESET;
      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      build_directed();
      foreach (directed[i])
         send_track(directed[i].trk,
                    directed[i].typed ? directed[i].want : predict_features(directed[i].trk));
      run_random(180);

      set_thresholds(0, 0, 1);
      run_random(170);
      set_thresholds(16'hFFFF, 24'hFF_FFFF, 20'hF_FFFF);
      run_random(160);
      set_thresholds(0, 0, 0);                  // zero knee and zero limit
      run_random(160);
      set_thresholds(7, 1, 1);
      run_random(160);
      set_thresholds(200, 655, 10000);
      run_random(160);
      set_thresholds(16'hFFFF, 0, 500);
      run_random(150);

      repeat (DRAIN_WAIT) @(posedge clock);
      $display("Sent %0d track beats over seven register settings, %0d rsp beats checked.",
               sent_count, rsp_count);
      $display("Turning results: %0d, saturated radius: %0d, mismatches: %0d.",
               turn_count, sat_count, mismatches);
      if (mismatches == 0 && pending_features.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
